// ===== design/nmea_gga_rmc_stream_parser_macros.svh =====
// ---------------------------------------------------------------------------
// NMEA parser assertion macros
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef NMEA_GGA_RMC_STREAM_PARSER_MACROS_SVH
`define NMEA_GGA_RMC_STREAM_PARSER_MACROS_SVH

// same-cycle implication
`define NGRS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ngrs assertion failed");

// next-cycle implication
`define NGRS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ngrs assertion failed");

`endif

// ===== design/ngrs_pkg.sv =====
// ---------------------------------------------------------------------------
// NMEA parser package
// Characters, codes, per-field record and commit control types, constants.
// ---------------------------------------------------------------------------
package ngrs_pkg;

    localparam int MAX_SENTENCE_DEF = 255;
    localparam int MAX_FIELDS_DEF   = 15;
    localparam int FRAC_DIGITS_DEF  = 5;

    localparam int REC_FIELDS = 10;
    localparam int MIN_FIELDS = 10;
    localparam int FRAC_KEEP  = 7;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_F      = 8'h46;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_W      = 8'h57;
    localparam logic [7:0] CH_A_LO   = 8'h61;
    localparam logic [7:0] CH_F_LO   = 8'h66;

    localparam logic [50:0] LAT_LIMIT  = 51'd900000000;
    localparam logic [50:0] LON_LIMIT  = 51'd1800000000;
    localparam logic [35:0] ALT_LOW    = 36'd100000;
    localparam logic [35:0] ALT_HIGH   = 36'd1000000;
    localparam logic [38:0] HDOP_MAX   = 39'd9999;
    localparam logic [31:0] SATS_MAX   = 32'd99;
    localparam logic [11:0] YEAR_BASE  = 12'd2000;
    localparam logic [31:0] DEG_SCALE  = 32'd10000000;
    localparam logic [31:0] DIV100_MUL = 32'd2748779070;
    localparam logic [28:0] DIV15_MUL  = 29'd286331154;

    typedef enum logic [1:0] {
        TYPE_NONE,
        TYPE_GGA,
        TYPE_RMC
    } stype_t;

    typedef enum logic [1:0] {
        PH_SIGN,
        PH_INT,
        PH_FRAC,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        ACT_CLR_FIX,
        ACT_GGA_FIX,
        ACT_RMC_FIX
    } act_t;

    typedef struct packed {
        logic [5:0][7:0] head;
        logic [2:0]      len;
        phase_t          phase;
        logic            neg;
        logic [31:0]     ival;
        logic [3:0]      acc1;
        logic [6:0]      acc2;
        logic [23:0]     accf;
        logic [2:0]      fcnt;
    } rec_t;

    typedef struct packed {
        act_t               act;
        logic               tupd;
        logic               dupd;
        logic [6:0]         sats;
        logic [13:0]        hdop;
        logic signed [20:0] alt;
        logic [6:0]         hour;
        logic [6:0]         minute;
        logic [6:0]         second;
        logic [6:0]         day;
        logic [6:0]         month;
        logic [11:0]        year;
    } ctl_t;

    function automatic logic [23:0] pow10(input logic [2:0] n);
        logic [23:0] r;
        case (n)
            3'd0:    r = 24'd1;
            3'd1:    r = 24'd10;
            3'd2:    r = 24'd100;
            3'd3:    r = 24'd1000;
            3'd4:    r = 24'd10000;
            3'd5:    r = 24'd100000;
            3'd6:    r = 24'd1000000;
            default: r = 24'd10000000;
        endcase
        return r;
    endfunction

endpackage

// ===== design/nmea_gga_rmc_stream_parser.sv =====
// ---------------------------------------------------------------------------
// NMEA GGA/RMC stream parser: one character word per cycle, sustained while rx_stall is low.
// A result word passes stages s1 to s5 and then the output register; the 5-stage commit path
// (coordinate scaling multiplies) stalls only when a result meets a full output.
// Async reset clears sentence state, commit pipeline valid flags and all latched values.
// ---------------------------------------------------------------------------
module nmea_gga_rmc_stream_parser #(
    parameter int MAX_SENTENCE = ngrs_pkg::MAX_SENTENCE_DEF,
    parameter int MAX_FIELDS   = ngrs_pkg::MAX_FIELDS_DEF,
    parameter int FRAC_DIGITS  = ngrs_pkg::FRAC_DIGITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rx_valid,
    output logic               rx_stall,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               has_fix,
    output logic signed [30:0] latitude,
    output logic signed [31:0] longitude,
    output logic [6:0]         satellites,
    output logic [13:0]        hdop,
    output logic signed [20:0] altitude,
    output logic [6:0]         hour,
    output logic [6:0]         minute,
    output logic [6:0]         second,
    output logic [6:0]         day,
    output logic [6:0]         month,
    output logic [11:0]        year
);
    import ngrs_pkg::*;

    localparam int LW = $clog2(MAX_SENTENCE + 1);
    localparam int FW = $clog2(MAX_FIELDS);
    localparam logic [2:0]  FD       = 3'(FRAC_DIGITS);
    localparam logic [23:0] FRAC_PAD = pow10(3'(FRAC_KEEP - FRAC_DIGITS));

    function automatic logic [4:0] hex_dec(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= CH_ZERO && c <= CH_NINE) r = {1'b1, 4'(c - CH_ZERO)};
        else if (c >= CH_A && c <= CH_F) r = {1'b1, 4'(c - CH_A + 8'd10)};
        else if (c >= CH_A_LO && c <= CH_F_LO) r = {1'b1, 4'(c - CH_A_LO + 8'd10)};
        return r;
    endfunction

    function automatic rec_t feed(input rec_t r, input logic [7:0] c);
        rec_t        o;
        phase_t      ph;
        logic        dig;
        logic        sgn;
        logic [3:0]  d;
        logic [35:0] v;
        o   = r;
        dig = (c >= CH_ZERO && c <= CH_NINE);
        d   = 4'(c - CH_ZERO);
        sgn = 1'b0;
        v   = {4'b0, r.ival} * 36'd10 + 36'(d);
        if (r.len < 3'd6) o.head[r.len] = c;
        if (r.len != 3'd7) o.len = r.len + 3'd1;
        ph = r.phase;
        if (ph == PH_SIGN) begin
            ph = PH_INT;
            if (c == CH_PLUS || c == CH_MINUS) begin
                sgn   = 1'b1;
                o.neg = (c == CH_MINUS);
            end
        end
        o.phase = ph;
        if (!sgn) begin
            case (ph)
                PH_INT: begin
                    if (dig) o.ival = (v[35:32] != 4'd0) ? '1 : v[31:0];
                    else if (c == CH_DOT) o.phase = PH_FRAC;
                    else o.phase = PH_DONE;
                end
                PH_FRAC: begin
                    if (dig) begin
                        if (r.fcnt < 3'(FRAC_KEEP)) begin
                            o.fcnt = r.fcnt + 3'd1;
                            if (r.fcnt == 3'd0) o.acc1 = d;
                            if (r.fcnt < 3'd2)
                                o.acc2 = r.acc2 + ((r.fcnt == 3'd0) ? 7'(d) * 7'd10 : 7'(d));
                            if (r.fcnt < FD)
                                o.accf = r.accf + 24'(d) * pow10(FD - 3'd1 - r.fcnt);
                        end
                    end else begin
                        o.phase = PH_DONE;
                    end
                end
                default: ;
            endcase
        end
        return o;
    endfunction

    // sentence state
    logic [LW-1:0] len_reg, len_next;
    logic [7:0]    xor_reg, xor_next;
    logic          star_reg, star_next;
    logic          hex_reg, hex_next;
    logic [7:0]    chk_reg, chk_next;
    logic [FW-1:0] fld_reg, fld_next;
    logic          fnz_reg, fnz_next;
    stype_t        type_reg, type_next;
    stype_t        cand_reg, cand_next;
    logic          dollar_reg, dollar_next;
    logic          frozen_reg, frozen_next;
    rec_t          rec_reg  [1:REC_FIELDS-1];
    rec_t          rec_next [1:REC_FIELDS-1];

    logic adv, accept, nl, ok_next;
    logic [4:0] hx;

    assign adv      = !(out_valid_reg && out_stall && s5_valid_reg);
    assign rx_stall = !adv;
    assign accept   = rx_valid && adv;
    assign nl       = (rx_byte == CH_NL);
    assign hx       = hex_dec(rx_byte);

    always_comb
    begin
        if (rx_byte == CH_DOLLAR) begin
            len_next = '0; xor_next = '0; star_next = 1'b0; hex_next = 1'b0;
            chk_next = '0; fld_next = '0; fnz_next = 1'b0; type_next = TYPE_NONE;
            cand_next = TYPE_NONE; dollar_next = 1'b0; frozen_next = 1'b0;
            for (int i = 1; i < REC_FIELDS; i++) rec_next[i] = '0;
        end else begin
            len_next = len_reg; xor_next = xor_reg; star_next = star_reg;
            hex_next = hex_reg; chk_next = chk_reg; fld_next = fld_reg;
            fnz_next = fnz_reg; type_next = type_reg; cand_next = cand_reg;
            dollar_next = dollar_reg; frozen_next = frozen_reg;
            for (int i = 1; i < REC_FIELDS; i++) rec_next[i] = rec_reg[i];
        end
        if (len_next < LW'(MAX_SENTENCE)) begin
            if (!frozen_next) begin
                if (rx_byte == CH_NUL) begin
                    frozen_next = 1'b1;
                end else begin
                    if (len_next == '0) begin
                        dollar_next = (rx_byte == CH_DOLLAR);
                    end else if (!star_next) begin
                        if (rx_byte == CH_STAR) begin
                            star_next = 1'b1;
                            hex_next  = 1'b1;
                        end else begin
                            xor_next = xor_next ^ rx_byte;
                        end
                    end else if (hex_next) begin
                        if (hx[4]) chk_next = {chk_next[3:0], hx[3:0]};
                        else hex_next = 1'b0;
                    end
                    if (len_next == LW'(3)) begin
                        cand_next = (rx_byte == CH_G) ? TYPE_GGA :
                                    (rx_byte == CH_R) ? TYPE_RMC : TYPE_NONE;
                    end else if (len_next == LW'(4)) begin
                        if ((cand_next == TYPE_GGA && rx_byte != CH_G) ||
                            (cand_next == TYPE_RMC && rx_byte != CH_M))
                            cand_next = TYPE_NONE;
                    end else if (len_next == LW'(5)) begin
                        if ((cand_next == TYPE_GGA && rx_byte == CH_A) ||
                            (cand_next == TYPE_RMC && rx_byte == CH_C))
                            type_next = cand_next;
                    end
                    if (rx_byte == CH_COMMA && fld_next < FW'(MAX_FIELDS - 1)) begin
                        fld_next = fld_next + 1'b1;
                        fnz_next = 1'b0;
                    end else begin
                        fnz_next = 1'b1;
                        for (int i = 1; i < REC_FIELDS; i++)
                            if (fld_next == FW'(i)) rec_next[i] = feed(rec_next[i], rx_byte);
                    end
                end
            end
            len_next = len_next + 1'b1;
        end
        ok_next = dollar_next && star_next && (xor_next == chk_next) &&
                  (type_next != TYPE_NONE) &&
                  (({1'b0, fld_next} + (FW+1)'(fnz_next)) >= (FW+1)'(MIN_FIELDS));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            len_reg <= '0; xor_reg <= '0; star_reg <= 1'b0; hex_reg <= 1'b0;
            chk_reg <= '0; fld_reg <= '0; fnz_reg <= 1'b0; type_reg <= TYPE_NONE;
            cand_reg <= TYPE_NONE; dollar_reg <= 1'b0; frozen_reg <= 1'b0;
            for (int i = 1; i < REC_FIELDS; i++) rec_reg[i] <= '0;
        end else if (accept) begin
            if (nl) begin
                len_reg <= '0; xor_reg <= '0; star_reg <= 1'b0; hex_reg <= 1'b0;
                chk_reg <= '0; fld_reg <= '0; fnz_reg <= 1'b0; type_reg <= TYPE_NONE;
                cand_reg <= TYPE_NONE; dollar_reg <= 1'b0; frozen_reg <= 1'b0;
                for (int i = 1; i < REC_FIELDS; i++) rec_reg[i] <= '0;
            end else begin
                len_reg <= len_next; xor_reg <= xor_next; star_reg <= star_next;
                hex_reg <= hex_next; chk_reg <= chk_next; fld_reg <= fld_next;
                fnz_reg <= fnz_next; type_reg <= type_next; cand_reg <= cand_next;
                dollar_reg <= dollar_next; frozen_reg <= frozen_next;
                for (int i = 1; i < REC_FIELDS; i++) rec_reg[i] <= rec_next[i];
            end
        end
    end

    // stage 1: sentence snapshot
    logic   s1_valid_reg;
    logic   s1_ok_reg;
    stype_t s1_type_reg;
    rec_t   s1_rec_reg [1:REC_FIELDS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s1_valid_reg <= 1'b0;
        else if (adv) s1_valid_reg <= accept && nl;
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            s1_ok_reg   <= ok_next;
            s1_type_reg <= type_next;
            for (int i = 1; i < REC_FIELDS; i++) s1_rec_reg[i] <= rec_next[i];
        end
    end

    // stage 1 decode
    ctl_t        ctl1;
    rec_t        crd [2];
    logic [7:0]  dir [2];
    logic        gga;
    logic [38:0] hsum;
    logic [35:0] asum;
    logic [11:0] yr_pair;

    always_comb
    begin
        gga    = (s1_type_reg == TYPE_GGA);
        crd[0] = gga ? s1_rec_reg[2] : s1_rec_reg[3];
        crd[1] = gga ? s1_rec_reg[4] : s1_rec_reg[5];
        dir[0] = gga ? s1_rec_reg[3].head[0] : s1_rec_reg[4].head[0];
        dir[1] = gga ? s1_rec_reg[5].head[0] : s1_rec_reg[6].head[0];
        if (gga) ctl1.act = (!s1_rec_reg[6].neg && s1_rec_reg[6].ival != '0) ?
                            ACT_GGA_FIX : ACT_CLR_FIX;
        else ctl1.act = (s1_rec_reg[2].head[0] == CH_A) ? ACT_RMC_FIX : ACT_CLR_FIX;
        ctl1.tupd = (s1_rec_reg[1].len >= 3'd6);
        ctl1.dupd = (s1_rec_reg[9].len >= 3'd6);
        ctl1.sats = s1_rec_reg[7].neg ? 7'd0 :
                    (s1_rec_reg[7].ival > SATS_MAX) ? 7'(SATS_MAX) : s1_rec_reg[7].ival[6:0];
        hsum = {7'b0, s1_rec_reg[8].ival} * 39'd100 + 39'(s1_rec_reg[8].acc2);
        ctl1.hdop = s1_rec_reg[8].neg ? 14'd0 :
                    (hsum > HDOP_MAX) ? 14'(HDOP_MAX) : hsum[13:0];
        asum = {4'b0, s1_rec_reg[9].ival} * 36'd10 + 36'(s1_rec_reg[9].acc1);
        if (s1_rec_reg[9].neg)
            ctl1.alt = (asum > ALT_LOW) ? -21'(ALT_LOW) : -21'(asum);
        else
            ctl1.alt = (asum > ALT_HIGH) ? 21'(ALT_HIGH) : 21'(asum);
        ctl1.hour   = 7'((s1_rec_reg[1].head[0] - CH_ZERO) * 8'd10 +
                         (s1_rec_reg[1].head[1] - CH_ZERO));
        ctl1.minute = 7'((s1_rec_reg[1].head[2] - CH_ZERO) * 8'd10 +
                         (s1_rec_reg[1].head[3] - CH_ZERO));
        ctl1.second = 7'((s1_rec_reg[1].head[4] - CH_ZERO) * 8'd10 +
                         (s1_rec_reg[1].head[5] - CH_ZERO));
        ctl1.day    = 7'((s1_rec_reg[9].head[0] - CH_ZERO) * 8'd10 +
                         (s1_rec_reg[9].head[1] - CH_ZERO));
        ctl1.month  = 7'((s1_rec_reg[9].head[2] - CH_ZERO) * 8'd10 +
                         (s1_rec_reg[9].head[3] - CH_ZERO));
        yr_pair     = (12'(s1_rec_reg[9].head[4]) - 12'(CH_ZERO)) * 12'd10 +
                      (12'(s1_rec_reg[9].head[5]) - 12'(CH_ZERO));
        ctl1.year   = YEAR_BASE + yr_pair;
    end

    // coordinate lanes: 0 latitude, 1 longitude
    logic        s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    ctl_t        s2_ctl_reg, s3_ctl_reg, s4_ctl_reg, s5_ctl_reg;
    logic [31:0] s2_ival_reg  [2];
    logic [25:0] s2_q_reg     [2];
    logic [23:0] s2_accf_reg  [2];
    logic [23:0] s3_accf_reg  [2];
    logic [6:0]  s3_rem_reg   [2];
    logic [49:0] s3_degs_reg  [2];
    logic [49:0] s4_degs_reg  [2];
    logic [49:0] s5_degs_reg  [2];
    logic [29:0] s4_p_reg     [2];
    logic [24:0] s5_q15_reg   [2];
    logic        s2_neg_reg [2], s3_neg_reg [2], s4_neg_reg [2], s5_neg_reg [2];
    logic        s2_emp_reg [2], s3_emp_reg [2], s4_emp_reg [2], s5_emp_reg [2];

    logic [63:0] prod100 [2];
    logic [56:0] prod15  [2];
    logic [50:0] mag     [2];
    logic [31:0] magc    [2];
    logic [31:0] coord   [2];

    always_comb
    begin
        for (int k = 0; k < 2; k++) begin
            prod100[k] = 64'(crd[k].ival) * 64'(DIV100_MUL);
            prod15[k]  = 57'(s4_p_reg[k][29:2]) * 57'(DIV15_MUL);
            mag[k]     = 51'(s5_degs_reg[k]) + 51'(s5_q15_reg[k]);
            if (mag[k] > ((k == 0) ? LAT_LIMIT : LON_LIMIT))
                magc[k] = (k == 0) ? LAT_LIMIT[31:0] : LON_LIMIT[31:0];
            else
                magc[k] = mag[k][31:0];
            if (s5_emp_reg[k]) coord[k] = '0;
            else coord[k] = s5_neg_reg[k] ? -magc[k] : magc[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end else if (adv) begin
            s2_valid_reg <= s1_valid_reg && s1_ok_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            s2_ctl_reg <= ctl1;
            s3_ctl_reg <= s2_ctl_reg;
            s4_ctl_reg <= s3_ctl_reg;
            s5_ctl_reg <= s4_ctl_reg;
            for (int k = 0; k < 2; k++) begin
                s2_ival_reg[k] <= crd[k].ival;
                s2_q_reg[k]    <= prod100[k][63:38];
                s2_accf_reg[k] <= crd[k].accf;
                s2_neg_reg[k]  <= crd[k].neg ^ (dir[k] == CH_S || dir[k] == CH_W);
                s2_emp_reg[k]  <= (crd[k].len == 3'd0);

                s3_rem_reg[k]  <= 7'(s2_ival_reg[k] - 32'({6'b0, s2_q_reg[k]} * 32'd100));
                s3_degs_reg[k] <= 50'(s2_q_reg[k]) * 50'(DEG_SCALE);
                s3_accf_reg[k] <= s2_accf_reg[k];
                s3_neg_reg[k]  <= s2_neg_reg[k];
                s3_emp_reg[k]  <= s2_emp_reg[k];

                s4_p_reg[k]    <= 30'(32'(s3_rem_reg[k]) * DEG_SCALE +
                                      32'(s3_accf_reg[k]) * 32'(FRAC_PAD));
                s4_degs_reg[k] <= s3_degs_reg[k];
                s4_neg_reg[k]  <= s3_neg_reg[k];
                s4_emp_reg[k]  <= s3_emp_reg[k];

                s5_q15_reg[k]  <= prod15[k][56:32];
                s5_degs_reg[k] <= s4_degs_reg[k];
                s5_neg_reg[k]  <= s4_neg_reg[k];
                s5_emp_reg[k]  <= s4_emp_reg[k];
            end
        end
    end

    // committed values double as the output word
    logic               out_valid_reg;
    logic               fix_reg;
    logic signed [30:0] lat_reg;
    logic signed [31:0] lon_reg;
    logic [6:0]         sats_reg;
    logic [13:0]        hdop_reg;
    logic signed [20:0] alt_reg;
    logic [6:0]         hour_reg, minute_reg, second_reg, day_reg, month_reg;
    logic [11:0]        year_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            fix_reg    <= 1'b0;
            lat_reg    <= '0;
            lon_reg    <= '0;
            sats_reg   <= '0;
            hdop_reg   <= '0;
            alt_reg    <= '0;
            hour_reg   <= '0;
            minute_reg <= '0;
            second_reg <= '0;
            day_reg    <= '0;
            month_reg  <= '0;
            year_reg   <= '0;
        end else if (adv) begin
            if (s5_valid_reg) begin
                out_valid_reg <= 1'b1;
                unique case (s5_ctl_reg.act)
                    ACT_GGA_FIX: begin
                        fix_reg  <= 1'b1;
                        lat_reg  <= 31'(coord[0]);
                        lon_reg  <= coord[1];
                        sats_reg <= s5_ctl_reg.sats;
                        hdop_reg <= s5_ctl_reg.hdop;
                        alt_reg  <= s5_ctl_reg.alt;
                    end
                    ACT_RMC_FIX: begin
                        fix_reg <= 1'b1;
                        lat_reg <= 31'(coord[0]);
                        lon_reg <= coord[1];
                        if (s5_ctl_reg.tupd) begin
                            hour_reg   <= s5_ctl_reg.hour;
                            minute_reg <= s5_ctl_reg.minute;
                            second_reg <= s5_ctl_reg.second;
                        end
                        if (s5_ctl_reg.dupd) begin
                            day_reg   <= s5_ctl_reg.day;
                            month_reg <= s5_ctl_reg.month;
                            year_reg  <= s5_ctl_reg.year;
                        end
                    end
                    default: fix_reg <= 1'b0;
                endcase
            end else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign has_fix    = fix_reg;
    assign latitude   = lat_reg;
    assign longitude  = lon_reg;
    assign satellites = sats_reg;
    assign hdop       = hdop_reg;
    assign altitude   = alt_reg;
    assign hour       = hour_reg;
    assign minute     = minute_reg;
    assign second     = second_reg;
    assign day        = day_reg;
    assign month      = month_reg;
    assign year       = year_reg;

endmodule

// ===== design/ngrs_chk.sv =====
// ---------------------------------------------------------------------------
// NMEA parser port checker
// Watches the parser ports; bound to the top level below.
// ---------------------------------------------------------------------------
`include "nmea_gga_rmc_stream_parser_macros.svh"

module ngrs_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               rx_valid,
    input logic               rx_stall,
    input logic [7:0]         rx_byte,
    input logic               out_valid,
    input logic               out_stall,
    input logic               has_fix,
    input logic signed [30:0] latitude,
    input logic signed [31:0] longitude,
    input logic [6:0]         satellites,
    input logic [13:0]        hdop,
    input logic signed [20:0] altitude,
    input logic [6:0]         hour,
    input logic [6:0]         minute,
    input logic [6:0]         second,
    input logic [6:0]         day,
    input logic [6:0]         month,
    input logic [11:0]        year
);

    `NGRS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

    `NGRS_ASSERT_NEXT(a_word_stable, out_valid && out_stall, $stable(has_fix) && $stable(latitude) && $stable(longitude) && $stable(altitude) && $stable(year))

    // input backs up only behind a blocked result word
    `NGRS_ASSERT_NOW(a_stall_cause, rx_stall, out_valid && out_stall)

    `NGRS_ASSERT_NOW(a_ranges, out_valid, latitude >= -32'sd900000000 && latitude <= 32'sd900000000 && longitude >= -32'sd1800000000 && longitude <= 32'sd1800000000 && satellites <= 7'd99 && hdop <= 14'd9999)

endmodule

bind nmea_gga_rmc_stream_parser ngrs_chk u_ngrs_chk (.*);
